/* rtl/lcab_pkg.sv */
// Shared types and constants for the lowest-common-ancestor block.
// Used by the sequencer and the top level; depends on nothing.
package lcab_pkg;

  // Input field widths of one transaction.
  localparam int NODE_W  = 8;
  localparam int DEPTH_W = 8;
  localparam int ACT_W   = 2;

  // Last bit position of a depth difference.
  localparam logic [2:0] DIFF_BIT_LAST = 3'(DEPTH_W - 1);

  // Action codes carried in the input tuser.
  localparam logic [ACT_W-1:0] ACT_LOAD  = 2'd0;
  localparam logic [ACT_W-1:0] ACT_BUILD = 2'd1;
  localparam logic [ACT_W-1:0] ACT_QUERY = 2'd2;

  // Result handed from the sequencer to the output register.
  typedef struct packed {
    logic              valid;
    logic              answer_valid;
    logic [NODE_W-1:0] common_ancestor;
  } res_t;

endpackage

/* rtl/lcab_ram.sv */
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Stand-alone; used for the ancestor table and the depth store.
module lcab_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* rtl/lcab_engine.sv */
// Sequencer for load, build and query transactions over the two RAMs.
// Depends on lcab_pkg; the RAMs themselves sit in the top level.
module lcab_engine #(
  parameter int NODE_COUNT  = 256,
  parameter int LEVEL_COUNT = 8,
  localparam int NW = $clog2(NODE_COUNT),
  localparam int LW = $clog2(LEVEL_COUNT)
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [lcab_pkg::ACT_W-1:0]       action,
  input  logic [NW-1:0]                    first_node,
  input  logic [NW-1:0]                    second_node,
  input  logic [NW-1:0]                    parent_node,
  input  logic [lcab_pkg::DEPTH_W-1:0]     node_depth,
  output logic                             tbl_we,
  output logic [NW+LW-1:0]                 tbl_waddr,
  output logic [NW-1:0]                    tbl_wdata,
  output logic [NW+LW-1:0]                 tbl_raddr,
  input  logic [NW-1:0]                    tbl_rdata,
  output logic                             dep_we,
  output logic [NW-1:0]                    dep_waddr,
  output logic [lcab_pkg::DEPTH_W-1:0]     dep_wdata,
  output logic [NW-1:0]                    dep_raddr,
  input  logic [lcab_pkg::DEPTH_W-1:0]     dep_rdata,
  output lcab_pkg::res_t                   res,
  input  logic                             res_ready
);

  typedef enum logic [11:0] {
    ST_IDLE      = 12'b0000_0000_0001,
    ST_DEP_A     = 12'b0000_0000_0010,
    ST_DEP_B     = 12'b0000_0000_0100,
    ST_LIFT_SEL  = 12'b0000_0000_1000,
    ST_LIFT_WAIT = 12'b0000_0001_0000,
    ST_WALK_CHK  = 12'b0000_0010_0000,
    ST_WALK_A    = 12'b0000_0100_0000,
    ST_WALK_B    = 12'b0000_1000_0000,
    ST_BUILD_RD1 = 12'b0001_0000_0000,
    ST_BUILD_RD2 = 12'b0010_0000_0000,
    ST_BUILD_WR  = 12'b0100_0000_0000,
    ST_FIN       = 12'b1000_0000_0000
  } state_t;

  state_t                        state;
  logic [NW-1:0]                 node_a;
  logic [NW-1:0]                 node_b;
  logic [lcab_pkg::DEPTH_W-1:0]  depth_a;
  logic [lcab_pkg::DEPTH_W-1:0]  diff;
  logic [2:0]                    bit_pos;
  logic [lcab_pkg::DEPTH_W-1:0]  reps;
  logic [NW:0]                   steps;
  logic [NW-1:0]                 build_node;
  logic [LW-1:0]                 build_level;
  logic                          rd_zero;
  logic                          dep_zero;
  logic [lcab_pkg::NODE_W-1:0]   answer;
  logic                          answer_valid;

  logic [NW-1:0]                 tbl_rnode;
  logic [LW-1:0]                 tbl_rlevel;
  logic [LW-1:0]                 lift_level;
  logic [NW-1:0]                 tbl_q;
  logic [lcab_pkg::DEPTH_W-1:0]  dep_q;
  logic [lcab_pkg::DEPTH_W-1:0]  rep_count;

  // Node 0 is the sentinel: its depth and all its ancestors read as zero.
  assign tbl_q = rd_zero ? '0 : tbl_rdata;
  assign dep_q = dep_zero ? '0 : dep_rdata;

  assign in_ready  = (state == ST_IDLE);
  assign tbl_raddr = {tbl_rnode, tbl_rlevel};

  assign res.valid           = (state == ST_FIN);
  assign res.answer_valid    = answer_valid;
  assign res.common_ancestor = answer;

  // Level used for a lift, and how many lifts one difference bit costs.
  // Bits beyond the table are applied as repeated lifts through the top level.
  always_comb begin
    if (int'(bit_pos) < LEVEL_COUNT) begin
      lift_level = LW'(bit_pos);
      rep_count  = 8'd1;
    end else begin
      lift_level = LW'(LEVEL_COUNT - 1);
      rep_count  = 8'(8'd1 << (int'(bit_pos) - LEVEL_COUNT + 1));
    end
  end

  // Memory port addressing for each step of the sequence.
  always_comb begin
    tbl_rnode  = node_a;
    tbl_rlevel = '0;
    tbl_we     = 1'b0;
    tbl_waddr  = {first_node, LW'(0)};
    tbl_wdata  = parent_node;
    dep_we     = 1'b0;
    dep_waddr  = first_node;
    dep_wdata  = node_depth;
    dep_raddr  = first_node;
    case (state)
      ST_IDLE: begin
        if (in_valid && action == lcab_pkg::ACT_LOAD && first_node != '0) begin
          tbl_we = 1'b1;
          dep_we = 1'b1;
        end
      end
      ST_DEP_A: begin
        dep_raddr = node_b;
      end
      ST_LIFT_SEL: begin
        tbl_rnode  = node_a;
        tbl_rlevel = lift_level;
      end
      ST_LIFT_WAIT: begin
        tbl_rnode  = tbl_q;
        tbl_rlevel = lift_level;
      end
      ST_WALK_CHK: begin
        tbl_rnode = node_a;
      end
      ST_WALK_A: begin
        tbl_rnode = node_b;
      end
      ST_BUILD_RD1: begin
        tbl_rnode  = build_node;
        tbl_rlevel = LW'(build_level - LW'(1));
      end
      ST_BUILD_RD2: begin
        tbl_rnode  = tbl_q;
        tbl_rlevel = LW'(build_level - LW'(1));
      end
      ST_BUILD_WR: begin
        tbl_we    = 1'b1;
        tbl_waddr = {build_node, build_level};
        tbl_wdata = tbl_q;
      end
      default: begin
      end
    endcase
  end

  // Remember whether each read targets the sentinel node.
  always_ff @(posedge clk) begin
    rd_zero  <= (tbl_rnode == '0);
    dep_zero <= (dep_raddr == '0);
  end

  // Sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      case (state)
        ST_IDLE: begin
          if (in_valid) begin
            node_a       <= first_node;
            node_b       <= second_node;
            answer       <= '0;
            answer_valid <= 1'b0;
            build_node   <= NW'(1);
            build_level  <= LW'(1);
            case (action)
              lcab_pkg::ACT_BUILD: state <= ST_BUILD_RD1;
              lcab_pkg::ACT_QUERY: state <= ST_DEP_A;
              default:             state <= ST_FIN;
            endcase
          end
        end
        ST_DEP_A: begin
          depth_a <= dep_q;
          state   <= ST_DEP_B;
        end
        ST_DEP_B: begin
          // Keep the deeper node in node_a.
          if (depth_a < dep_q) begin
            node_a <= node_b;
            node_b <= node_a;
            diff   <= 8'(dep_q - depth_a);
          end else begin
            diff   <= 8'(depth_a - dep_q);
          end
          bit_pos <= '0;
          steps   <= '0;
          state   <= ST_LIFT_SEL;
        end
        ST_LIFT_SEL: begin
          if (diff[bit_pos]) begin
            reps  <= 8'(rep_count - 8'd1);
            state <= ST_LIFT_WAIT;
          end else if (bit_pos == lcab_pkg::DIFF_BIT_LAST) begin
            state <= ST_WALK_CHK;
          end else begin
            bit_pos <= 3'(bit_pos + 3'd1);
          end
        end
        ST_LIFT_WAIT: begin
          node_a <= tbl_q;
          if (reps != '0) begin
            reps <= 8'(reps - 8'd1);
          end else if (bit_pos == lcab_pkg::DIFF_BIT_LAST) begin
            state <= ST_WALK_CHK;
          end else begin
            bit_pos <= 3'(bit_pos + 3'd1);
            state   <= ST_LIFT_SEL;
          end
        end
        ST_WALK_CHK: begin
          // Stop when the two meet, or give up on a tree that never joins.
          if (node_a == node_b) begin
            answer       <= 8'(node_a);
            answer_valid <= 1'b1;
            state        <= ST_FIN;
          end else if (steps >= (NW+1)'(NODE_COUNT)) begin
            answer       <= '0;
            answer_valid <= 1'b1;
            state        <= ST_FIN;
          end else begin
            state <= ST_WALK_A;
          end
        end
        ST_WALK_A: begin
          node_a <= tbl_q;
          state  <= ST_WALK_B;
        end
        ST_WALK_B: begin
          node_b <= tbl_q;
          steps  <= (NW+1)'(steps + 1'b1);
          state  <= ST_WALK_CHK;
        end
        ST_BUILD_RD1: begin
          state <= ST_BUILD_RD2;
        end
        ST_BUILD_RD2: begin
          state <= ST_BUILD_WR;
        end
        ST_BUILD_WR: begin
          // Sweep nodes 1 .. NODE_COUNT-1 within each level, levels in order.
          if (build_node == NW'(NODE_COUNT - 1)) begin
            build_node <= NW'(1);
            if (build_level == LW'(LEVEL_COUNT - 1)) begin
              state <= ST_FIN;
            end else begin
              build_level <= LW'(build_level + LW'(1));
              state       <= ST_BUILD_RD1;
            end
          end else begin
            build_node <= NW'(build_node + NW'(1));
            state      <= ST_BUILD_RD1;
          end
        end
        ST_FIN: begin
          if (res_ready) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

/* rtl/lca_binary_lifting_top.sv */
// Top level of the lowest-common-ancestor block: input decode, the two RAMs,
// the sequencer and the output register. Depends on lcab_pkg, lcab_ram, lcab_engine.
//
//   channel   direction  tdata                                  tuser
//   s_axis    in         first/second/parent node, node depth   action
//   m_axis    out        common ancestor                        answer valid
//
// A load writes both RAMs; a build reads two ancestors and writes one entry per node and level.
// A query reads both depths, visits each of the 8 difference bit positions, makes one lift
// per table read, and steps both nodes to their parents until they meet; the single table
// read port serialises these reads.
// Reset clears control state only; RAM contents stay undefined until written.
// A new transaction is taken while a result waits in the output register.
module lca_binary_lifting_top #(
  parameter int NODE_COUNT  = 256,
  parameter int LEVEL_COUNT = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // first_node, second_node, parent_node, node_depth
  input  logic [1:0]  s_axis_tuser,   // action
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // common_ancestor
  output logic        m_axis_tuser    // answer_valid
);

  localparam int NW = $clog2(NODE_COUNT);
  localparam int LW = $clog2(LEVEL_COUNT);

  logic [NW-1:0]                node_lut [256];
  logic [NW-1:0]                first_node;
  logic [NW-1:0]                second_node;
  logic [NW-1:0]                parent_node;
  logic                         tbl_we;
  logic [NW+LW-1:0]             tbl_waddr;
  logic [NW-1:0]                tbl_wdata;
  logic [NW+LW-1:0]             tbl_raddr;
  logic [NW-1:0]                tbl_rdata;
  logic                         dep_we;
  logic [NW-1:0]                dep_waddr;
  logic [lcab_pkg::DEPTH_W-1:0] dep_wdata;
  logic [NW-1:0]                dep_raddr;
  logic [lcab_pkg::DEPTH_W-1:0] dep_rdata;
  lcab_pkg::res_t               res;
  logic                         res_ready;

  // Node numbers are reduced modulo NODE_COUNT through a constant table.
  for (genvar g = 0; g < 256; g++) begin : g_node_lut
    assign node_lut[g] = NW'(g % NODE_COUNT);
  end

  assign first_node  = node_lut[s_axis_tdata[7:0]];
  assign second_node = node_lut[s_axis_tdata[15:8]];
  assign parent_node = node_lut[s_axis_tdata[23:16]];

  // Ancestor table, addressed by node and level.
  lcab_ram #(
    .WIDTH (NW),
    .DEPTH (NODE_COUNT * (2 ** LW))
  ) u_tbl_ram (
    .clk   (clk),
    .we    (tbl_we),
    .waddr (tbl_waddr),
    .wdata (tbl_wdata),
    .raddr (tbl_raddr),
    .rdata (tbl_rdata)
  );

  // Depth store, one entry per node.
  lcab_ram #(
    .WIDTH (lcab_pkg::DEPTH_W),
    .DEPTH (NODE_COUNT)
  ) u_dep_ram (
    .clk   (clk),
    .we    (dep_we),
    .waddr (dep_waddr),
    .wdata (dep_wdata),
    .raddr (dep_raddr),
    .rdata (dep_rdata)
  );

  lcab_engine #(
    .NODE_COUNT  (NODE_COUNT),
    .LEVEL_COUNT (LEVEL_COUNT)
  ) u_engine (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (s_axis_tvalid),
    .in_ready    (s_axis_tready),
    .action      (s_axis_tuser),
    .first_node  (first_node),
    .second_node (second_node),
    .parent_node (parent_node),
    .node_depth  (s_axis_tdata[31:24]),
    .tbl_we      (tbl_we),
    .tbl_waddr   (tbl_waddr),
    .tbl_wdata   (tbl_wdata),
    .tbl_raddr   (tbl_raddr),
    .tbl_rdata   (tbl_rdata),
    .dep_we      (dep_we),
    .dep_waddr   (dep_waddr),
    .dep_wdata   (dep_wdata),
    .dep_raddr   (dep_raddr),
    .dep_rdata   (dep_rdata),
    .res         (res),
    .res_ready   (res_ready)
  );

  // Output register; it takes a new result when empty or being drained.
  assign res_ready = !m_axis_tvalid || m_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (res.valid && res_ready) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res.valid && res_ready) begin
      m_axis_tdata <= res.common_ancestor;
      m_axis_tuser <= res.answer_valid;
    end
  end

endmodule

/* rtl/lcab_checker.sv */
// Port-level checker for the lowest-common-ancestor top level, bound to it below.
// Depends on the top level's ports only.
module lcab_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic [31:0] s_axis_tdata,
  input logic [1:0]  s_axis_tuser,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [7:0]  m_axis_tdata,
  input logic        m_axis_tuser
);

  logic       in_acc;
  logic       out_acc;
  logic [2:0] pending;

  assign in_acc  = s_axis_tvalid && s_axis_tready;
  assign out_acc = m_axis_tvalid && m_axis_tready;

  // Transactions taken in whose results have not yet left.
  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
    end else begin
      pending <= 3'(pending + {2'b0, in_acc} - {2'b0, out_acc});
    end
  end

  // A stalled result holds its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("stalled result changed");

  // Only a query result carries a nonzero ancestor.
  a_plain_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata == 8'd0)
    else $error("non-query result carries an ancestor");

  // Every result belongs to an earlier transaction, and at most two are in flight.
  a_no_extra: assert property (@(posedge clk) disable iff (rst)
    (!m_axis_tvalid || pending != 3'd0) && pending <= 3'd2)
    else $error("result count out of step with accepted transactions");

  // The sequencer is busy in the cycle after it takes a transaction.
  a_busy_after: assert property (@(posedge clk) disable iff (rst)
    in_acc |=> !s_axis_tready)
    else $error("input ready right after a transaction");

endmodule

bind lca_binary_lifting_top lcab_checker u_lcab_checker (.*);
